// ----- hdl/crc8d_pkg.sv -----
// shared types, constants and the crc-8 byte step for the packet deframer
package crc8d_pkg;

   // framing bytes
   localparam logic [7:0] SYNC_BYTE      = 8'h55;
   localparam logic [7:0] CRC_POLY       = 8'h07;
   localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

   // command codes
   localparam logic [7:0] CMD_LED    = 8'h4C;
   localparam logic [7:0] CMD_THRESH = 8'h43;
   localparam logic [7:0] CMD_POLL   = 8'h46;

   // fixed lengths of the threshold and poll commands
   localparam logic [7:0] THRESH_LEN = 8'd5;
   localparam logic [7:0] POLL_LEN   = 8'd0;

   // register reset values
   localparam logic [7:0] MAX_LEN_RESET = 8'd80;
   localparam logic [7:0] LED_LEN_RESET = 8'd75;

   // register indexes on the csr port
   localparam logic [7:0] REG_PANEL_ADDR = 8'd0;
   localparam logic [7:0] REG_MAX_LEN    = 8'd1;
   localparam logic [7:0] REG_LED_LEN    = 8'd2;

   // frame class codes
   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_LED    = 2'd1;
   localparam logic [1:0] CLASS_THRESH = 2'd2;
   localparam logic [1:0] CLASS_POLL   = 2'd3;

   // configuration registers as seen by the parser
   typedef struct packed {
      logic [7:0] panel_address;
      logic [7:0] max_payload_length;
      logic [7:0] led_frame_length;
   } cfg_type;

   // one result
   typedef struct packed {
      logic        is_frame_end;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  command_code;
      logic [7:0]  frame_addr;
      logic [7:0]  payload_length;
      logic        crc_ok;
      logic [1:0]  frame_class;
      logic [31:0] crc_error_total;
   } rsp_type;

   // crc-8, msb first, one byte folded in
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ----- hdl/crc8_packet_deframer.sv -----
// top level of the sync/length/crc-8 packet deframer
//
// usage: received bus bytes enter one per request on the req_ channel
// (req_valid/req_ready, byte on req_rx_byte). the block hunts for the sync
// byte, captures command, address and length, passes each payload byte out
// on the rsp_ channel with its index, and gives one end-of-frame response
// for the crc byte with the verdict, the frame class and the crc error count.
// header bytes, sync hunting and dropped over-length frames give no response.
// a response is registered, valid the cycle after its request is accepted.
// throughput: one request per cycle; the single result register sets this,
// and req_ready stays high while that register is empty or being drained.
// when the receiver stalls rsp_ready, the held response stays put and
// req_ready drops, so no request is taken whose response has no room.
// configuration is written on the csr_ channel (csr_ready is always high); the
// user must write it only while no frame is in progress (the block does not
// enforce this). unknown indexes are ignored. reset (synchronous, active high)
// returns to the hunt, clears the error count and loads the register defaults.
module crc8_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_frame_end,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_command_code,
   output logic [7:0]  rsp_frame_addr,
   output logic [7:0]  rsp_payload_length,
   output logic        rsp_crc_ok,
   output logic [1:0]  rsp_frame_class,
   output logic [31:0] rsp_crc_error_total,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]         panel_addr_ff;
   logic [7:0]         max_len_ff;
   logic [7:0]         led_len_ff;
   crc8d_pkg::cfg_type cfg;
   logic               accept;
   logic               res_valid;
   crc8d_pkg::rsp_type res_data;
   crc8d_pkg::rsp_type out_data;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         panel_addr_ff <= 8'd0;
         max_len_ff    <= crc8d_pkg::MAX_LEN_RESET;
         led_len_ff    <= crc8d_pkg::LED_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crc8d_pkg::REG_PANEL_ADDR: panel_addr_ff <= csr_data;
            crc8d_pkg::REG_MAX_LEN:    max_len_ff    <= csr_data;
            crc8d_pkg::REG_LED_LEN:    led_len_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.panel_address      = panel_addr_ff;
   assign cfg.max_payload_length = max_len_ff;
   assign cfg.led_frame_length   = led_len_ff;

   // request handshake
   assign accept = req_valid && req_ready;

   crc8d_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .rsp_valid (res_valid),
      .rsp       (res_data)
   );

   crc8d_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_ready (rsp_ready)
   );

   // response fields
   assign rsp_is_frame_end    = out_data.is_frame_end;
   assign rsp_payload_byte    = out_data.payload_byte;
   assign rsp_payload_index   = out_data.payload_index;
   assign rsp_command_code    = out_data.command_code;
   assign rsp_frame_addr      = out_data.frame_addr;
   assign rsp_payload_length  = out_data.payload_length;
   assign rsp_crc_ok          = out_data.crc_ok;
   assign rsp_frame_class     = out_data.frame_class;
   assign rsp_crc_error_total = out_data.crc_error_total;

endmodule

// ----- hdl/crc8d_parser.sv -----
// frame parser: phase tracking, crc update, classification and result forming
module crc8d_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  crc8d_pkg::cfg_type   cfg,
   output logic                 rsp_valid,
   output crc8d_pkg::rsp_type   rsp
);

   typedef enum logic [2:0] {
      ST_HUNT = 3'd0,
      ST_CMD  = 3'd1,
      ST_ADDR = 3'd2,
      ST_LEN  = 3'd3,
      ST_PAY  = 3'd4,
      ST_CRC  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [31:0] err_ff, err_in;
   logic [7:0]  crc_next;
   logic [7:0]  count_inc;
   logic        own_addr;
   logic [1:0]  class_code;

   // shared byte step and counter increment
   assign crc_next  = crc8d_pkg::crc8_step(crc_ff, rx_byte);
   assign count_inc = count_ff + 8'd1;

   // frame class from the held header
   assign own_addr = (addr_ff == cfg.panel_address);
   always_comb begin
      class_code = crc8d_pkg::CLASS_NONE;
      if (cmd_ff == crc8d_pkg::CMD_LED &&
          (own_addr || addr_ff == crc8d_pkg::BROADCAST_ADDR) &&
          len_ff == cfg.led_frame_length) begin
         class_code = crc8d_pkg::CLASS_LED;
      end else if (cmd_ff == crc8d_pkg::CMD_THRESH && own_addr &&
                   len_ff == crc8d_pkg::THRESH_LEN) begin
         class_code = crc8d_pkg::CLASS_THRESH;
      end else if (cmd_ff == crc8d_pkg::CMD_POLL && own_addr &&
                   len_ff == crc8d_pkg::POLL_LEN) begin
         class_code = crc8d_pkg::CLASS_POLL;
      end
   end

   // next state and result for an accepted byte
   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      err_in    = err_ff;
      rsp_valid = 1'b0;
      rsp.is_frame_end    = 1'b0;
      rsp.payload_byte    = 8'd0;
      rsp.payload_index   = 8'd0;
      rsp.command_code    = cmd_ff;
      rsp.frame_addr      = addr_ff;
      rsp.payload_length  = len_ff;
      rsp.crc_ok          = 1'b0;
      rsp.frame_class     = crc8d_pkg::CLASS_NONE;
      rsp.crc_error_total = err_ff;
      if (accept) begin
         case (phase_ff)
            ST_CMD: begin
               cmd_in   = rx_byte;
               crc_in   = crc8d_pkg::crc8_step(8'd0, rx_byte);
               phase_in = ST_ADDR;
            end
            ST_ADDR: begin
               addr_in  = rx_byte;
               crc_in   = crc_next;
               phase_in = ST_LEN;
            end
            ST_LEN: begin
               len_in   = rx_byte;
               count_in = 8'd0;
               crc_in   = crc_next;
               if (rx_byte > cfg.max_payload_length) begin
                  phase_in = ST_HUNT;
               end else if (rx_byte != 8'd0) begin
                  phase_in = ST_PAY;
               end else begin
                  phase_in = ST_CRC;
               end
            end
            ST_PAY: begin
               rsp_valid         = 1'b1;
               rsp.payload_byte  = rx_byte;
               rsp.payload_index = count_ff;
               crc_in            = crc_next;
               count_in          = count_inc;
               if (count_inc == len_ff) begin
                  phase_in = ST_CRC;
               end
            end
            ST_CRC: begin
               rsp_valid        = 1'b1;
               rsp.is_frame_end = 1'b1;
               if (crc_ff == rx_byte) begin
                  rsp.crc_ok      = 1'b1;
                  rsp.frame_class = class_code;
               end else begin
                  err_in = err_ff + 32'd1;
               end
               rsp.crc_error_total = err_in;
               phase_in = ST_HUNT;
            end
            default: begin
               phase_in = (rx_byte == crc8d_pkg::SYNC_BYTE) ? ST_CMD : ST_HUNT;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_HUNT;
         cmd_ff   <= 8'd0;
         addr_ff  <= 8'd0;
         len_ff   <= 8'd0;
         count_ff <= 8'd0;
         crc_ff   <= 8'd0;
         err_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         addr_ff  <= addr_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ----- hdl/crc8d_rsp_reg.sv -----
// result register between the parser and the response channel
module crc8d_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  crc8d_pkg::rsp_type   in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output crc8d_pkg::rsp_type   out_data,
   input  logic                 out_ready
);

   logic               valid_ff;
   crc8d_pkg::rsp_type data_ff;

   // room when empty or when the held result leaves this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule
